>>> rtl/rtbm_pkg.sv
// Shared types and constants for the RGB to Bayer RGGB10 mosaic block.
package rtbm_pkg;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_HEIGHT_DEF    = 4096;
    localparam int CHECK_SAMPLES_DEF = 128;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // Pixel formats; codes at and above FMT_RAW pass raw samples
    localparam logic [2:0] FMT_BGR32 = 3'd0;
    localparam logic [2:0] FMT_RGB32 = 3'd1;
    localparam logic [2:0] FMT_BGR24 = 3'd2;
    localparam logic [2:0] FMT_RGB24 = 3'd3;
    localparam logic [2:0] FMT_RAW   = 3'd4;

    localparam logic [2:0]  FMT_RESET    = FMT_RAW;
    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    localparam logic [15:0] RAW_LIMIT = 16'h03ff;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_LOOKUP,
        OP_RAW
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  addr;
        logic [15:0] value;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_end;
        logic        warn;
    } t_op;

endpackage

>>> rtl/rtbm_front.sv
// Front part: position tracking, channel selection, range check and queue push.
module rtbm_front #(
    parameter int MAX_WIDTH     = rtbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = rtbm_pkg::MAX_HEIGHT_DEF,
    parameter int CHECK_SAMPLES = rtbm_pkg::CHECK_SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtbm_pkg::t_cfg  i_cfg,
    input  logic            i_accept,
    input  logic            i_command,
    input  logic [31:0]     i_data_word,
    input  logic [7:0]      i_table_index,
    input  logic [9:0]      i_table_value,
    output logic            o_q_push,
    output rtbm_pkg::t_op   o_q_op
);

    localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int KW    = $clog2(CHECK_SAMPLES + 1);
    localparam int DIM_W = (CW > RW) ? CW : RW;
    localparam int SZ_W  = (DIM_W + 3 > 14) ? DIM_W + 3 : 14;

    localparam logic [SZ_W-1:0] W_MAX = SZ_W'(MAX_WIDTH);
    localparam logic [SZ_W-1:0] H_MAX = SZ_W'(MAX_HEIGHT);
    localparam logic [KW-1:0]   K_MAX = KW'(CHECK_SAMPLES);
    localparam logic [SZ_W-1:0] ONE   = SZ_W'(1);
    localparam logic [SZ_W-1:0] TWO   = SZ_W'(2);

    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [KW-1:0]   r_chk, n_chk;
    logic            r_warned, n_warned;

    logic [SZ_W-1:0] fw, fh, eff_w, eff_h, col_x, row_x;
    logic            row_end, last_row, odd_w, is_raw, bgr, produces, is_pixel;
    logic            chk_open, warn, fend_rgb;
    logic [7:0]      red_byte, green_byte, blue_byte, chan;
    logic [15:0]     raw_sample;

    always_comb begin
        fw    = SZ_W'(i_cfg.frame_width);
        fh    = SZ_W'(i_cfg.frame_height);
        eff_w = (fw == '0) ? ONE : ((fw > W_MAX) ? W_MAX : fw);
        eff_h = (fh == '0) ? ONE : ((fh > H_MAX) ? H_MAX : fh);
        col_x = SZ_W'(r_col);
        row_x = SZ_W'(r_row);

        row_end  = (col_x + ONE) >= eff_w;
        last_row = (row_x + ONE) >= eff_h;
        odd_w    = eff_w[0];
        is_raw   = i_cfg.pixel_format >= rtbm_pkg::FMT_RAW;
        bgr      = (i_cfg.pixel_format == rtbm_pkg::FMT_BGR32) ||
                   (i_cfg.pixel_format == rtbm_pkg::FMT_BGR24);
        produces = !(odd_w && row_end);
        is_pixel = (i_command == rtbm_pkg::CMD_PIXEL);

        red_byte   = bgr ? i_data_word[23:16] : i_data_word[7:0];
        green_byte = i_data_word[15:8];
        blue_byte  = bgr ? i_data_word[7:0] : i_data_word[23:16];
        if (!r_row[0]) begin
            chan = r_col[0] ? green_byte : red_byte;
        end else begin
            chan = r_col[0] ? blue_byte : green_byte;
        end

        // odd width drops the last column, so the frame ends one column early
        fend_rgb = last_row && (odd_w ? ((col_x + TWO) >= eff_w) : row_end);

        raw_sample = i_data_word[15:0];
        chk_open   = r_chk < K_MAX;
        warn       = chk_open && !r_warned && (raw_sample > rtbm_pkg::RAW_LIMIT);
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_chk    = r_chk;
        n_warned = r_warned;
        if (i_accept && is_pixel) begin
            if (is_raw && chk_open) begin
                n_chk = r_chk + KW'(1);
                if (warn) begin
                    n_warned = 1'b1;
                end
            end
            if (row_end) begin
                n_col = '0;
                if (last_row) begin
                    n_row = '0;
                    n_chk = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_chk    <= '0;
            r_warned <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_chk    <= n_chk;
            r_warned <= n_warned;
        end
    end

    always_comb begin
        o_q_push         = i_accept && (!is_pixel || is_raw || produces);
        o_q_op.column    = 12'(r_col);
        o_q_op.row       = 12'(r_row);
        o_q_op.frame_end = 1'b0;
        o_q_op.warn      = 1'b0;
        if (!is_pixel) begin
            o_q_op.kind  = rtbm_pkg::OP_WRITE;
            o_q_op.addr  = i_table_index;
            o_q_op.value = {6'd0, i_table_value};
        end else if (is_raw) begin
            o_q_op.kind      = rtbm_pkg::OP_RAW;
            o_q_op.addr      = '0;
            o_q_op.value     = raw_sample;
            o_q_op.frame_end = row_end && last_row;
            o_q_op.warn      = warn;
        end else begin
            o_q_op.kind      = rtbm_pkg::OP_LOOKUP;
            o_q_op.addr      = chan;
            o_q_op.value     = '0;
            o_q_op.frame_end = fend_rgb;
        end
    end

endmodule

>>> rtl/rtbm_queue.sv
// Short request queue between the front and back parts.
module rtbm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtbm_pkg::t_op  i_op,
    output logic           o_full,
    output logic           o_vld,
    output rtbm_pkg::t_op  o_op,
    input  logic           i_pop
);

    localparam logic [rtbm_pkg::QCNT_W-1:0] DEPTH_CNT =
        rtbm_pkg::QCNT_W'(rtbm_pkg::QUEUE_DEPTH);

    rtbm_pkg::t_op                 r_mem [rtbm_pkg::QUEUE_DEPTH];
    logic [rtbm_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [rtbm_pkg::QCNT_W-1:0]   r_cnt, n_cnt;
    logic                          do_push, do_pop;

    assign o_full  = (r_cnt == DEPTH_CNT);
    assign o_vld   = (r_cnt != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + rtbm_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - rtbm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + rtbm_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + rtbm_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

>>> rtl/rtbm_back.sv
// Back part: sample table, table lookup stage and result register.
module rtbm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_vld,
    input  rtbm_pkg::t_op  i_q_op,
    output logic           o_q_pop,
    output logic           o_vld,
    output logic [15:0]    o_sample,
    output logic [11:0]    o_out_column,
    output logic [11:0]    o_out_row,
    output logic           o_frame_end,
    output logic           o_range_warning,
    input  logic           i_pop
);

    logic [9:0]     r_table [256];
    logic [9:0]     r_rd_data;
    logic           r_s1_vld;
    rtbm_pkg::t_op  r_s1;
    logic           r_out_vld;
    logic [15:0]    r_sample;
    logic [11:0]    r_column, r_row;
    logic           r_frame_end, r_warn;

    logic           s1_adv, is_write, s1_load;

    always_comb begin
        s1_adv   = r_s1_vld && (!r_out_vld || i_pop);
        o_q_pop  = i_q_vld && (!r_s1_vld || s1_adv);
        is_write = (i_q_op.kind == rtbm_pkg::OP_WRITE);
        s1_load  = o_q_pop && !is_write;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && is_write) begin
            r_table[i_q_op.addr] <= i_q_op.value[9:0];
        end
        if (s1_load) begin
            r_rd_data <= r_table[i_q_op.addr];
            r_s1      <= i_q_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_sample    <= (r_s1.kind == rtbm_pkg::OP_LOOKUP) ? {6'd0, r_rd_data}
                                                               : r_s1.value;
            r_column    <= r_s1.column;
            r_row       <= r_s1.row;
            r_frame_end <= r_s1.frame_end;
            r_warn      <= r_s1.warn;
        end
    end

    assign o_vld           = r_out_vld;
    assign o_sample        = r_sample;
    assign o_out_column    = r_column;
    assign o_out_row       = r_row;
    assign o_frame_end     = r_frame_end;
    assign o_range_warning = r_warn;

endmodule

>>> rtl/rgb_to_bayer_rggb10_mosaic.sv
// Top level: configuration registers and the front, queue and back parts.
//
// Input channel (push/full): one item per accepted push. A pixel item
// carries one source pixel in raster order; a table item writes one entry
// of the 256 x 10-bit channel-to-sample table. Table entries must be
// written before pixels read them.
// Result channel (empty/pop): one Bayer sample per producing pixel, with
// its column, row, end-of-frame flag and raw range warning.
// Throughput: one item per clock, sustained, while results are popped.
// A result passes through the queue entry, the table read register and
// the result register on its way to the ports.
// A four-entry queue separates the front, which tracks the position, from
// the back, which holds the table and the result register; a stalled pop
// fills the back and then the queue before full rises.
// Configuration (APB, pready tied high) must be written while the block
// is idle; the block does not enforce this. Reset clears the position,
// the range check state and all queued work, and loads pixel_format =
// raw, frame_width = 640, frame_height = 480. Reset leaves the table.
module rgb_to_bayer_rggb10_mosaic #(
    parameter int MAX_WIDTH     = rtbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = rtbm_pkg::MAX_HEIGHT_DEF,
    parameter int CHECK_SAMPLES = rtbm_pkg::CHECK_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [31:0] i_data_word,
    input  logic [7:0]  i_table_index,
    input  logic [9:0]  i_table_value,
    // results
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_sample,
    output logic [11:0] o_out_column,
    output logic [11:0] o_out_row,
    output logic        o_frame_end,
    output logic        o_range_warning
);

    logic [2:0]      r_pixel_format;
    logic [12:0]     r_frame_width, r_frame_height;
    logic            cfg_wr;
    logic [1:0]      reg_idx;
    rtbm_pkg::t_cfg  cfg;

    logic            accept, q_push, q_full, q_vld, q_pop, out_vld;
    rtbm_pkg::t_op   q_in_op, q_out_op;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= rtbm_pkg::FMT_RESET;
            r_frame_width  <= rtbm_pkg::WIDTH_RESET;
            r_frame_height <= rtbm_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rtbm_pkg::REG_PIXEL_FORMAT: r_pixel_format <= pwdata[2:0];
                rtbm_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[12:0];
                rtbm_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rtbm_pkg::REG_PIXEL_FORMAT: prdata = {29'd0, r_pixel_format};
            rtbm_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, r_frame_width};
            rtbm_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, r_frame_height};
            default:                    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.pixel_format = r_pixel_format;
        cfg.frame_width  = r_frame_width;
        cfg.frame_height = r_frame_height;
    end

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_vld;

    rtbm_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .CHECK_SAMPLES (CHECK_SAMPLES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_data_word   (i_data_word),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .o_q_push      (q_push),
        .o_q_op        (q_in_op)
    );

    rtbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_op    (q_out_op),
        .i_pop   (q_pop)
    );

    rtbm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_op          (q_out_op),
        .o_q_pop         (q_pop),
        .o_vld           (out_vld),
        .o_sample        (o_sample),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_frame_end     (o_frame_end),
        .o_range_warning (o_range_warning),
        .i_pop           (pop)
    );

endmodule

>>> tb/sv/tb_rgb_to_bayer_rggb10_mosaic.sv
// Testbench for the RGB to Bayer RGGB10 mosaic: random requests checked against a predictor.
module tb_rgb_to_bayer_rggb10_mosaic;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_PAD   = 8;
    localparam int unsigned END_PAD     = 20;

    typedef struct packed {
        logic        command;
        logic [31:0] word;
        logic [7:0]  index;
        logic [9:0]  value;
    } t_mosaic_item;

    typedef struct packed {
        logic [15:0] sample;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_end;
        logic        warn;
    } t_bayer_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic        full;
    logic        i_command     = rtbm_pkg::CMD_PIXEL;
    logic [31:0] i_data_word   = '0;
    logic [7:0]  i_table_index = '0;
    logic [9:0]  i_table_value = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic [15:0] o_sample;
    logic [11:0] o_out_column;
    logic [11:0] o_out_row;
    logic        o_frame_end;
    logic        o_range_warning;

    // Predictor state and its copy of the registers
    logic [2:0]  cfg_fmt    = rtbm_pkg::FMT_RESET;
    logic [12:0] cfg_width  = rtbm_pkg::WIDTH_RESET;
    logic [12:0] cfg_height = rtbm_pkg::HEIGHT_RESET;
    int unsigned pos_col     = 0;
    int unsigned pos_row     = 0;
    int unsigned raw_checked = 0;
    bit          warned      = 1'b0;
    logic [9:0]  pred_table [256];

    t_mosaic_item  source_items [$];
    t_bayer_result bayer_due [$];
    t_mosaic_item  cur_item;
    logic [7:0]    loaded_codes [$];
    bit            is_loaded [256];

    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    int unsigned send_gap        = 0;
    int unsigned pop_stall       = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    rgb_to_bayer_rggb10_mosaic u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_command       (i_command),
        .i_data_word     (i_data_word),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .empty           (empty),
        .pop             (pop),
        .o_sample        (o_sample),
        .o_out_column    (o_out_column),
        .o_out_row       (o_out_row),
        .o_frame_end     (o_frame_end),
        .o_range_warning (o_range_warning)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input logic [12:0] v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Pixel word whose three channel bytes all hit loaded table entries
    function automatic logic [31:0] loaded_word();
        logic [31:0] w;
        w = $urandom;
        for (int b = 0; b < 3; b++)
            w[8*b +: 8] = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        return w;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic mosaic_step(input t_mosaic_item it);
        int unsigned   w;
        int unsigned   h;
        bit            row_end;
        bit            last_row;
        bit            odd_w;
        bit            bgr;
        logic [1:0]    lane;
        t_bayer_result r;
        w = clamp_size(cfg_width, rtbm_pkg::MAX_WIDTH_DEF);
        h = clamp_size(cfg_height, rtbm_pkg::MAX_HEIGHT_DEF);
        if (it.command == rtbm_pkg::CMD_TABLE) begin
            pred_table[it.index] = it.value;
            return;
        end
        row_end  = (pos_col + 1 >= w);
        last_row = (pos_row + 1 >= h);
        r.column = pos_col[11:0];
        r.row    = pos_row[11:0];
        r.warn   = 1'b0;
        if (cfg_fmt >= rtbm_pkg::FMT_RAW) begin
            r.sample = it.word[15:0];
            if (raw_checked < rtbm_pkg::CHECK_SAMPLES_DEF) begin
                if (!warned && r.sample > rtbm_pkg::RAW_LIMIT) begin
                    warned = 1'b1;
                    r.warn = 1'b1;
                end
                raw_checked++;
            end
            r.frame_end = row_end && last_row;
            bayer_due.push_back(r);
        end else begin
            odd_w = w[0];
            // drop the last pixel of a row when the width is odd
            if (!(odd_w && row_end)) begin
                bgr = (cfg_fmt == rtbm_pkg::FMT_BGR32 || cfg_fmt == rtbm_pkg::FMT_BGR24);
                if (pos_row[0] == 1'b0)
                    lane = pos_col[0] ? 2'd1 : (bgr ? 2'd2 : 2'd0);
                else
                    lane = pos_col[0] ? (bgr ? 2'd0 : 2'd2) : 2'd1;
                r.sample    = {6'd0, pred_table[it.word[8*lane +: 8]]};
                r.frame_end = last_row && (odd_w ? (pos_col + 2 >= w) : row_end);
                bayer_due.push_back(r);
            end
        end
        if (row_end) begin
            pos_col = 0;
            if (last_row) begin
                pos_row     = 0;
                raw_checked = 0;
            end else begin
                pos_row = pos_row + 1;
            end
        end else begin
            pos_col = pos_col + 1;
        end
    endtask

    task automatic add_table(input logic [7:0] idx, input logic [9:0] val);
        t_mosaic_item it;
        it.command = rtbm_pkg::CMD_TABLE;
        it.word    = $urandom;
        it.index   = idx;
        it.value   = val;
        source_items.push_back(it);
        if (!is_loaded[idx]) begin
            is_loaded[idx] = 1'b1;
            loaded_codes.push_back(idx);
        end
    endtask

    task automatic add_data(input logic [31:0] word);
        t_mosaic_item it;
        it.command = rtbm_pkg::CMD_PIXEL;
        it.word    = word;
        it.index   = 8'($urandom);
        it.value   = 10'($urandom);
        source_items.push_back(it);
    endtask

    // Hold until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (source_items.size() != 0 || push || bayer_due.size() != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rtbm_pkg::REG_PIXEL_FORMAT: cfg_fmt    = val[2:0];
            rtbm_pkg::REG_FRAME_WIDTH:  cfg_width  = val[12:0];
            rtbm_pkg::REG_FRAME_HEIGHT: cfg_height = val[12:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [2:0] fmt, input logic [12:0] width,
                             input logic [12:0] height);
        wait_drained();
        reg_write(rtbm_pkg::REG_PIXEL_FORMAT, 32'(fmt));
        reg_write(rtbm_pkg::REG_FRAME_WIDTH, 32'(width));
        reg_write(rtbm_pkg::REG_FRAME_HEIGHT, 32'(height));
        sender_steady   = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Driver: one request at a time, held until full drops
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            send_gap  = 0;
        end else begin
            if (push && !full)
                mosaic_step(cur_item);
            if (!(push && full)) begin
                if (send_gap > 0) begin
                    push     <= 1'b0;
                    send_gap  = send_gap - 1;
                end else if (source_items.size() != 0) begin
                    cur_item       = source_items.pop_front();
                    push          <= 1'b1;
                    i_command     <= cur_item.command;
                    i_data_word   <= cur_item.word;
                    i_table_index <= cur_item.index;
                    i_table_value <= cur_item.value;
                    send_gap       = sender_steady ? 0 : pick_gap();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each popped result with the oldest one due
    always @(posedge i_clk) begin
        t_bayer_result want;
        if (!i_rst_n) begin
            pop       <= 1'b0;
            pop_stall  = 0;
        end else begin
            if (pop && !empty) begin
                if (bayer_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result sample %h row %0d col %0d",
                                            o_sample, o_out_row, o_out_column));
                end else begin
                    want = bayer_due.pop_front();
                    if (o_sample !== want.sample)
                        flag_mismatch($sformatf("sample %h, want %h (row %0d col %0d)",
                                                o_sample, want.sample, want.row, want.column));
                    if (o_out_column !== want.column)
                        flag_mismatch($sformatf("column %0d, want %0d",
                                                o_out_column, want.column));
                    if (o_out_row !== want.row)
                        flag_mismatch($sformatf("row %0d, want %0d", o_out_row, want.row));
                    if (o_frame_end !== want.frame_end)
                        flag_mismatch($sformatf("frame_end %b, want %b (row %0d col %0d)",
                                                o_frame_end, want.frame_end,
                                                want.row, want.column));
                    if (o_range_warning !== want.warn)
                        flag_mismatch($sformatf("range_warning %b, want %b (row %0d col %0d)",
                                                o_range_warning, want.warn,
                                                want.row, want.column));
                end
                pop_stall = receiver_steady ? 0 : pick_gap();
            end
            if (pop_stall > 0) begin
                pop       <= 1'b0;
                pop_stall  = pop_stall - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, bayer_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [7:0]  order [256];
        logic [7:0]  tmp;
        logic [15:0] s;
        logic [15:0] upper;
        logic [12:0] width;
        logic [12:0] height;
        int unsigned j;
        int unsigned n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: table extremes, then one short frame per layout
        configure(rtbm_pkg::FMT_BGR32, 13'd4, 13'd2);
        add_table(8'h00, 10'h3ff);
        add_table(8'hff, 10'h000);
        add_table(8'h55, 10'h2aa);
        add_table(8'haa, 10'h155);
        add_table(8'h0f, 10'h001);
        add_table(8'hf0, 10'h200);
        for (int k = 0; k < 8; k++) add_data(loaded_word());
        // odd width: last pixel of each row gives nothing
        configure(rtbm_pkg::FMT_RGB24, 13'd3, 13'd2);
        for (int k = 0; k < 6; k++) add_data(loaded_word());
        // width of one: no results at all
        configure(rtbm_pkg::FMT_RGB32, 13'd1, 13'd3);
        for (int k = 0; k < 3; k++) add_data(loaded_word());

        // Raw range check: samples past the first 128 of a frame never warn
        configure(rtbm_pkg::FMT_RAW, 13'd16, 13'd9);
        for (int k = 0; k < 144; k++) begin
            if (k == 72)
                wait_drained();
            if (k == 0) s = 16'h0000;
            else if (k == 1) s = rtbm_pkg::RAW_LIMIT;
            else if (k < 128) s = 16'($urandom_range(0, 16'h03ff));
            else if (k == 128) s = 16'h0400;
            else s = 16'($urandom_range(16'h0400, 16'hffff));
            upper = 16'($urandom);
            add_data({upper, s});
        end
        // next frame: the first large sample warns, later ones stay quiet
        for (int k = 0; k < 20; k++) begin
            upper = 16'($urandom);
            s = 16'($urandom_range(0, 16'h03ff));
            add_data({upper, s});
        end
        add_data(32'hffff_ffff);
        for (int k = 0; k < 40; k++) add_data($urandom);

        // Load the whole table in shuffled order
        for (int k = 0; k < 256; k++) order[k] = 8'(k);
        for (int k = 255; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < 256; k++) add_table(order[k], 10'($urandom_range(0, 1023)));

        // Random phases; position carries over across register changes
        for (int ph = 0; ph < 16; ph++) begin
            case ($urandom_range(0, 7))
                0: width = 13'd0;
                1: width = 13'd1;
                2: width = 13'd2;
                3: width = 13'd3;
                default: width = 13'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 5))
                0: height = 13'd0;
                1: height = 13'd1;
                default: height = 13'($urandom_range(1, 6));
            endcase
            configure((ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7)), width, height);
            n = $urandom_range(40, 90);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0)
                    add_table(8'($urandom), 10'($urandom));
                else if (cfg_fmt >= rtbm_pkg::FMT_RAW)
                    add_data($urandom);
                else
                    add_data(loaded_word());
            end
        end

        // Largest sizes: saturated width with zero height, then saturated height
        configure(rtbm_pkg::FMT_BGR24, 13'h1fff, 13'd0);
        for (int k = 0; k < 40; k++) add_data(loaded_word());
        configure(3'd7, 13'd1, 13'h1fff);
        for (int k = 0; k < 40; k++) add_data($urandom);

        wait_drained();
        repeat (END_PAD) @(posedge i_clk);
        if (bayer_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", bayer_due.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
